// File: rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion shorthands for the eertree block.
// Standalone header; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, c, r, ante, cons) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, c, r, ante, cons) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/pstb_pkg.sv
// pstb_pkg.sv: shared constants, field widths and beat structs of the eertree block.
// No dependencies.
package pstb_pkg;

    localparam int DEF_MAX_LEN  = 1024;
    localparam int DEF_ALPHABET = 26;

    localparam int LETTER_W   = 5;
    localparam int POSITION_W = 10;
    localparam int COUNT_W    = 11;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                restart;
    } pstb_req_t;

    typedef struct packed {
        logic [POSITION_W-1:0] position;
        logic                  new_palindrome;
        logic [COUNT_W-1:0]    suffix_length;
        logic [COUNT_W-1:0]    suffix_count;
        logic [COUNT_W-1:0]    distinct_count;
        logic                  overflow;
    } pstb_res_t;

endpackage

// File: rtl/palindromic_suffix_tree_builder_unit.sv
// palindromic_suffix_tree_builder_unit.sv: top level, stream ports and output register.
// Depends on pstb_pkg, pstb_core and assert_macros.svh.
//
// channel   dir  tdata fields (lsb first)                                   tuser
// s_        in   letter[4:0], pad[7:5]                                       restart
// m_        out  position[9:0], new_palindrome, suffix_length[10:0],         overflow
//                suffix_count[10:0], distinct_count[10:0], pad[47:44]
//
// A letter walks the suffix links: each node visited takes a read and a position step, plus
// a text compare unless it is the odd root or wraps past the text start; a second walk seeks
// the new node's link when one is needed, and an overflow beat is answered from the idle state.
// These steps are set by the single-port registered reads of the shared walk unit.
// Reset (rst_n low, asynchronous) empties the tree; no clearing pass is needed.
// s_tready is low while a letter is in work or the result register is full and not taken.
`include "assert_macros.svh"

module palindromic_suffix_tree_builder_unit #(
    parameter int MAX_LEN  = pstb_pkg::DEF_MAX_LEN,
    parameter int ALPHABET = pstb_pkg::DEF_ALPHABET
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pstb_pkg::S_TDATA_W-1:0]  s_tdata,   // letter
    input  logic [0:0]                      s_tuser,   // restart
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pstb_pkg::M_TDATA_W-1:0]  m_tdata,   // position, new_palindrome, suffix_length,
                                                       // suffix_count, distinct_count
    output logic [0:0]                      m_tuser    // overflow
);
    import pstb_pkg::*;

    pstb_req_t req;
    pstb_res_t core_res;
    logic      core_idle;
    logic      core_done;
    logic      start;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    assign req.letter  = s_tdata[LETTER_W-1:0];
    assign req.restart = s_tuser[0];

    assign s_tready = core_idle && (!m_tvalid_reg || m_tready);
    assign start    = s_tvalid && s_tready;

    pstb_core #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .idle  (core_idle),
        .done  (core_done),
        .res   (core_res)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (core_done)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0000,
                             core_res.distinct_count,
                             core_res.suffix_count,
                             core_res.suffix_length,
                             core_res.new_palindrome,
                             core_res.position};
            m_tuser_next  = core_res.overflow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `ASSERT_IMP(a_slot_free, clk, rst_n, core_done, !m_tvalid_reg || m_tready)
    `ASSERT_NEXT(a_result_held, clk, rst_n, core_done, m_tvalid_reg)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !core_done, !core_idle)

endmodule

// File: rtl/pstb_core.sv
// pstb_core.sv: eertree sequencer, node/text/transition memories and the shared walk unit.
// Depends on pstb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pstb_core #(
    parameter int MAX_LEN  = pstb_pkg::DEF_MAX_LEN,
    parameter int ALPHABET = pstb_pkg::DEF_ALPHABET
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  pstb_pkg::pstb_req_t req,
    output logic                idle,
    output logic                done,
    output pstb_pkg::pstb_res_t res
);
    import pstb_pkg::*;

    localparam int NODES  = MAX_LEN + 2;
    localparam int NW     = $clog2(NODES);
    localparam int NCW    = $clog2(NODES + 1);
    localparam int TW     = $clog2(MAX_LEN + 1);
    localparam int SW     = TW + 2;
    localparam int CW     = $clog2(ALPHABET);
    localparam int KW     = NW + CW;
    localparam int TDEPTH = NODES * ALPHABET;
    localparam int AW     = $clog2(TDEPTH);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_W_RD  = 11'b00000000010,
        S_W_POS = 11'b00000000100,
        S_W_CMP = 11'b00000001000,
        S_T_RD  = 11'b00000010000,
        S_T_CHK = 11'b00000100000,
        S_T_VAL = 11'b00001000000,
        S_L_RD  = 11'b00010000000,
        S_L_WR  = 11'b00100000000,
        S_F_RD  = 11'b01000000000,
        S_F_OUT = 11'b10000000000
    } state_t;

    function automatic logic [COUNT_W-1:0] w11(input logic [31:0] x);
        return x[COUNT_W-1:0];
    endfunction

    function automatic logic [POSITION_W-1:0] w10(input logic [31:0] x);
        return x[POSITION_W-1:0];
    endfunction

    state_t                 state_reg, state_next;
    logic [NW-1:0]          last_reg, last_next;
    logic [TW-1:0]          tlen_reg, tlen_next;
    logic [NCW-1:0]         nc_reg, nc_next;
    logic [TW-1:0]          n_reg, n_next;
    logic [CW-1:0]          ch_reg, ch_next;
    logic [NW-1:0]          node_reg, node_next;
    logic                   walk2_reg, walk2_next;
    logic [NW-1:0]          cur_reg, cur_next;
    logic signed [SW-1:0]   curlen_reg, curlen_next;
    logic [NW-1:0]          curlink_reg, curlink_next;
    logic signed [SW-1:0]   wlen_reg, wlen_next;
    logic [NW-1:0]          wlink_reg, wlink_next;
    logic [NW-1:0]          tnode_reg, tnode_next;
    logic [NW-1:0]          v_reg, v_next;
    logic [NW-1:0]          link_reg, link_next;
    logic [TW-1:0]          newlen_reg, newlen_next;

    logic [CW-1:0] text_mem [0:MAX_LEN];
    logic [TW-1:0] nlen_mem [0:NODES-1];
    logic [NW-1:0] link_mem [0:NODES-1];
    logic [TW-1:0] depth_mem [0:NODES-1];
    logic [KW-1:0] key_mem [0:NODES-1];
    logic [NW-1:0] trans_mem [0:TDEPTH-1];

    logic [CW-1:0] text_rd;
    logic [TW-1:0] nlen_rd;
    logic [NW-1:0] link_rd;
    logic [TW-1:0] depth_rd;
    logic [KW-1:0] key_rd;
    logic [NW-1:0] trans_rd;

    logic          text_we;
    logic [TW-1:0] text_wa, text_ra;
    logic [CW-1:0] text_wd;
    logic          node_we;
    logic [NW-1:0] node_wa, node_ra;
    logic [TW-1:0] depth_wd;
    logic [NW-1:0] key_ra;
    logic          trans_we;
    logic [NW-1:0] tidx_node;
    logic [AW-1:0] tidx;

    logic [CW-1:0]        ch_in;
    logic [TW-1:0]        eff_tlen;
    logic [NCW-1:0]       eff_nc;
    logic [NW-1:0]        eff_last;
    logic                 ovf;
    logic signed [SW-1:0] len_s, pos_s, newlen_s;
    logic [NW-1:0]        link_n;
    logic                 exists;

    assign idle = (state_reg == S_IDLE);

    assign ch_in    = (32'(req.letter) >= ALPHABET) ? CW'(ALPHABET - 1) : CW'(req.letter);
    assign eff_tlen = req.restart ? '0 : tlen_reg;
    assign eff_nc   = req.restart ? NCW'(2) : nc_reg;
    assign eff_last = req.restart ? NW'(1) : last_reg;
    assign ovf      = (32'(eff_tlen) >= MAX_LEN);

    // shared walk unit: root constants, text offset of the candidate wrap
    always_comb
    begin
        if (node_reg == NW'(0))
        begin
            len_s  = '0;
            link_n = NW'(1);
        end
        else if (node_reg == NW'(1))
        begin
            len_s  = '1;
            link_n = NW'(0);
        end
        else
        begin
            len_s  = $signed({2'b00, nlen_rd});
            link_n = link_rd;
        end
        pos_s = $signed({2'b00, n_reg}) - len_s - $signed(SW'(1));
    end

    assign newlen_s  = curlen_reg + $signed(SW'(2));
    assign exists    = (v_reg >= NW'(2)) && (NCW'(v_reg) < nc_reg)
                       && (key_rd == {tnode_reg, ch_reg});
    assign tidx_node = (state_reg == S_L_WR) ? cur_reg : tnode_reg;
    assign tidx      = AW'(tidx_node) * AW'(ALPHABET) + AW'(ch_reg);
    assign depth_wd  = ((link_reg < NW'(2)) ? TW'(0) : depth_rd) + TW'(1);

    always_comb
    begin
        state_next   = state_reg;
        last_next    = last_reg;
        tlen_next    = tlen_reg;
        nc_next      = nc_reg;
        n_next       = n_reg;
        ch_next      = ch_reg;
        node_next    = node_reg;
        walk2_next   = walk2_reg;
        cur_next     = cur_reg;
        curlen_next  = curlen_reg;
        curlink_next = curlink_reg;
        wlen_next    = wlen_reg;
        wlink_next   = wlink_reg;
        tnode_next   = tnode_reg;
        v_next       = v_reg;
        link_next    = link_reg;
        newlen_next  = newlen_reg;

        text_we  = 1'b0;
        text_wa  = eff_tlen + TW'(1);
        text_wd  = ch_in;
        text_ra  = pos_s[TW-1:0];
        node_we  = 1'b0;
        node_wa  = nc_reg[NW-1:0];
        key_ra   = trans_rd;
        trans_we = 1'b0;

        unique case (state_reg)
            S_F_RD:  node_ra = last_reg;
            S_L_RD:  node_ra = link_reg;
            default: node_ra = node_reg;
        endcase

        done = 1'b0;
        res  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    nc_next   = eff_nc;
                    last_next = eff_last;
                    tlen_next = eff_tlen;
                    if (ovf)
                    begin
                        done               = 1'b1;
                        res.overflow       = 1'b1;
                        res.distinct_count = w11(32'(eff_nc) - 32'd2);
                    end
                    else
                    begin
                        text_we    = 1'b1;
                        tlen_next  = eff_tlen + TW'(1);
                        n_next     = eff_tlen + TW'(1);
                        ch_next    = ch_in;
                        node_next  = eff_last;
                        walk2_next = 1'b0;
                        state_next = S_W_RD;
                    end
                end
            end
            S_W_RD:
            begin
                state_next = S_W_POS;
            end
            S_W_POS:
            begin
                wlen_next  = len_s;
                wlink_next = link_n;
                if (node_reg == NW'(1))
                begin
                    tnode_next = node_reg;
                    if (!walk2_reg)
                    begin
                        cur_next     = node_reg;
                        curlen_next  = len_s;
                        curlink_next = link_n;
                    end
                    state_next = S_T_RD;
                end
                else if (pos_s <= $signed(SW'(0)))
                begin
                    node_next  = link_n;
                    state_next = S_W_RD;
                end
                else
                begin
                    state_next = S_W_CMP;
                end
            end
            S_W_CMP:
            begin
                if (text_rd == ch_reg)
                begin
                    tnode_next = node_reg;
                    if (!walk2_reg)
                    begin
                        cur_next     = node_reg;
                        curlen_next  = wlen_reg;
                        curlink_next = wlink_reg;
                    end
                    state_next = S_T_RD;
                end
                else
                begin
                    node_next  = wlink_reg;
                    state_next = S_W_RD;
                end
            end
            S_T_RD:
            begin
                state_next = S_T_CHK;
            end
            S_T_CHK:
            begin
                v_next     = trans_rd;
                state_next = S_T_VAL;
            end
            S_T_VAL:
            begin
                newlen_next = newlen_s[TW-1:0];
                if (walk2_reg)
                begin
                    link_next  = exists ? v_reg : NW'(0);
                    state_next = S_L_RD;
                end
                else if (exists)
                begin
                    last_next  = v_reg;
                    state_next = S_F_RD;
                end
                else if (nc_reg < NCW'(NODES))
                begin
                    if (cur_reg == NW'(1))
                    begin
                        link_next  = NW'(0);
                        state_next = S_L_RD;
                    end
                    else
                    begin
                        walk2_next = 1'b1;
                        node_next  = curlink_reg;
                        state_next = S_W_RD;
                    end
                end
                else
                begin
                    last_next  = NW'(0);
                    state_next = S_F_RD;
                end
            end
            S_L_RD:
            begin
                state_next = S_L_WR;
            end
            S_L_WR:
            begin
                node_we    = 1'b1;
                trans_we   = 1'b1;
                nc_next    = nc_reg + NCW'(1);
                last_next  = nc_reg[NW-1:0];
                state_next = S_IDLE;

                done               = 1'b1;
                res.position       = w10(32'(n_reg) - 32'd1);
                res.new_palindrome = 1'b1;
                res.suffix_length  = w11(32'(newlen_reg));
                res.suffix_count   = w11(32'(depth_wd));
                res.distinct_count = w11(32'(nc_reg) - 32'd1);
            end
            S_F_RD:
            begin
                state_next = S_F_OUT;
            end
            S_F_OUT:
            begin
                state_next = S_IDLE;

                done               = 1'b1;
                res.position       = w10(32'(n_reg) - 32'd1);
                res.suffix_length  = (last_reg < NW'(2)) ? '0 : w11(32'(nlen_rd));
                res.suffix_count   = (last_reg < NW'(2)) ? '0 : w11(32'(depth_rd));
                res.distinct_count = w11(32'(nc_reg) - 32'd2);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= NW'(1);
            tlen_reg  <= '0;
            nc_reg    <= NCW'(2);
            walk2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            tlen_reg  <= tlen_next;
            nc_reg    <= nc_next;
            walk2_reg <= walk2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        ch_reg      <= ch_next;
        node_reg    <= node_next;
        cur_reg     <= cur_next;
        curlen_reg  <= curlen_next;
        curlink_reg <= curlink_next;
        wlen_reg    <= wlen_next;
        wlink_reg   <= wlink_next;
        tnode_reg   <= tnode_next;
        v_reg       <= v_next;
        link_reg    <= link_next;
        newlen_reg  <= newlen_next;
    end

    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            text_mem[text_wa] <= text_wd;
        end
        text_rd <= text_mem[text_ra];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            nlen_mem[node_wa]  <= newlen_reg;
            link_mem[node_wa]  <= link_reg;
            depth_mem[node_wa] <= depth_wd;
            key_mem[node_wa]   <= {cur_reg, ch_reg};
        end
        nlen_rd  <= nlen_mem[node_ra];
        link_rd  <= link_mem[node_ra];
        depth_rd <= depth_mem[node_ra];
        key_rd   <= key_mem[key_ra];
    end

    // entries are trusted only when the child's key matches and it is below the node count
    always_ff @(posedge clk)
    begin
        if (trans_we)
        begin
            trans_mem[tidx] <= nc_reg[NW-1:0];
        end
        trans_rd <= trans_mem[tidx];
    end

    `ASSERT_IMP(a_nc_bound, clk, rst_n, 1'b1, nc_reg <= NCW'(NODES))
    `ASSERT_IMP(a_tlen_bound, clk, rst_n, 1'b1, tlen_reg <= TW'(MAX_LEN))
    `ASSERT_IMP(a_new_len, clk, rst_n, done && res.new_palindrome,
                res.suffix_length != '0 && !res.overflow)
    `ASSERT_NEXT(a_walk_start, clk, rst_n, state_reg == S_IDLE && start && !ovf,
                 state_reg == S_W_RD)

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// tb.sv: self-checking bench for the palindromic tree (eertree) builder unit.
// Depends on pstb_pkg and palindromic_suffix_tree_builder_unit; holds its own eertree
// predictor and checks each result beat against it, or against a typed row's own result.
module tb;
    import pstb_pkg::*;

    localparam int MAXL  = DEF_MAX_LEN;
    localparam int ALPHA = DEF_ALPHABET;
    localparam int NODES = MAXL + 2;

    localparam int NEWP_BIT = POSITION_W;
    localparam int SLEN_LO  = POSITION_W + 1;
    localparam int SCNT_LO  = SLEN_LO + COUNT_W;
    localparam int DCNT_LO  = SCNT_LO + COUNT_W;

    typedef struct packed {
        logic [POSITION_W-1:0] position;
        logic                  new_palindrome;
        logic [COUNT_W-1:0]    suffix_length;
        logic [COUNT_W-1:0]    suffix_count;
        logic [COUNT_W-1:0]    distinct_count;
        logic                  overflow;
    } pal_result_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                restart;
        logic                typed;
        pal_result_t         res;
    } stim_row_t;

    // single letter in an empty text
    localparam pal_result_t FIRST_LETTER = '{10'd0, 1'b1, 11'd1, 11'd1, 11'd1, 1'b0};

    localparam int N_DIRECTED = 23;
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{5'd0,  1'b0, 1'b1, FIRST_LETTER},
        '{5'd0,  1'b0, 1'b0, '0},
        '{5'd1,  1'b0, 1'b0, '0},
        '{5'd0,  1'b0, 1'b0, '0},
        '{5'd0,  1'b0, 1'b0, '0},
        '{5'd31, 1'b0, 1'b0, '0},
        '{5'd26, 1'b0, 1'b0, '0},
        '{5'd25, 1'b0, 1'b0, '0},
        '{5'd16, 1'b0, 1'b0, '0},
        '{5'd8,  1'b0, 1'b0, '0},
        '{5'd4,  1'b0, 1'b0, '0},
        '{5'd2,  1'b0, 1'b0, '0},
        '{5'd1,  1'b0, 1'b0, '0},
        '{5'd31, 1'b1, 1'b1, FIRST_LETTER},
        '{5'd0,  1'b1, 1'b1, FIRST_LETTER},
        '{5'd1,  1'b0, 1'b0, '0},
        '{5'd0,  1'b0, 1'b0, '0},
        '{5'd2,  1'b0, 1'b0, '0},
        '{5'd0,  1'b0, 1'b0, '0},
        '{5'd1,  1'b0, 1'b0, '0},
        '{5'd0,  1'b0, 1'b0, '0},
        '{5'd30, 1'b1, 1'b1, FIRST_LETTER},
        '{5'd27, 1'b0, 1'b0, '0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    int tx_idle_pct = 33;
    int rx_idle_pct = 63;
    int letters_sent = 0;
    int mismatches = 0;

    // predictor state
    int txt_letter [MAXL + 1];
    int child      [NODES][ALPHA];
    int link_to    [NODES];
    int pal_len    [NODES];
    int pal_depth  [NODES];
    int tail_node  = 0;
    int txt_len    = 0;
    int node_total = 0;

    pal_result_t suffix_reports [$];

    palindromic_suffix_tree_builder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // only nodes below node_total and text up to txt_len can be non-zero
    function automatic void tree_clear();
        int i;
        int c;
        for (i = 0; i < node_total; i++)
        begin
            for (c = 0; c < ALPHA; c++)
                child[i][c] = 0;
            link_to[i] = 0;
            pal_len[i] = 0;
            pal_depth[i] = 0;
        end
        for (i = 0; i <= txt_len; i++)
            txt_letter[i] = 0;
        pal_len[1] = -1;
        link_to[0] = 1;
        link_to[1] = 0;
        tail_node = 1;
        txt_len = 0;
        node_total = 2;
    endfunction

    // follow suffix links until the palindrome can be wrapped by ch at position n
    function automatic int wrap_point(input int node, input int n, input int ch);
        int p;
        int at;
        int steps;
        p = node;
        for (steps = 0; steps < NODES + 1; steps++)
        begin
            if (p >= NODES)
                return 1;
            at = n - pal_len[p] - 1;
            if (at == n)
                return p;
            if (at > 0 && at <= n && txt_letter[at] == ch)
                return p;
            p = link_to[p];
        end
        return 1;
    endfunction

    function automatic pal_result_t append_letter(input logic [LETTER_W-1:0] letter,
                                                  input logic restart);
        pal_result_t r;
        int ch;
        int n;
        int cur;
        int fresh;
        int lnk;
        int w;
        r = '0;
        if (restart)
            tree_clear();
        if (txt_len >= MAXL)
        begin
            r.distinct_count = COUNT_W'(node_total - 2);
            r.overflow = 1'b1;
            return r;
        end
        ch = (int'(letter) >= ALPHA) ? ALPHA - 1 : int'(letter);
        n = txt_len + 1;
        txt_letter[n] = ch;
        txt_len = n;
        cur = wrap_point(tail_node, n, ch);
        if (child[cur][ch] == 0 && node_total < NODES)
        begin
            fresh = node_total;
            pal_len[fresh] = pal_len[cur] + 2;
            if (pal_len[fresh] == 1)
                lnk = 0;
            else
            begin
                w = wrap_point(link_to[cur], n, ch);
                lnk = child[w][ch];
            end
            link_to[fresh] = lnk;
            pal_depth[fresh] = pal_depth[lnk] + 1;
            child[cur][ch] = fresh;
            node_total = fresh + 1;
            r.new_palindrome = 1'b1;
        end
        tail_node = child[cur][ch];
        if (tail_node >= NODES)
            tail_node = 1;
        r.position = POSITION_W'(n - 1);
        r.suffix_length = COUNT_W'(pal_len[tail_node] < 0 ? 0 : pal_len[tail_node]);
        r.suffix_count = COUNT_W'(pal_depth[tail_node]);
        r.distinct_count = COUNT_W'(node_total - 2);
        return r;
    endfunction

    task automatic push_letter(input logic [LETTER_W-1:0] letter, input logic restart,
                               input logic typed, input pal_result_t typed_res);
        pal_result_t want;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(letter);
        s_tuser <= restart;
        do
            @(posedge clk);
        while (!s_tready);
        want = append_letter(letter, restart);
        suffix_reports.insert(suffix_reports.size(), typed ? typed_res : want);
        letters_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (suffix_reports.size() != 0)
            @(posedge clk);
    endtask

    // short texts over a few neighbouring letters, with some stray letters mixed in
    task automatic short_texts(input int quota);
        int stop_at;
        int len;
        int span;
        int base;
        int i;
        logic [LETTER_W-1:0] l;
        stop_at = letters_sent + quota;
        while (letters_sent < stop_at)
        begin
            len = $urandom_range(1, 48);
            span = $urandom_range(1, 4);
            base = $urandom_range(0, 32 - span);
            for (i = 0; i < len; i++)
            begin
                if ($urandom_range(9) == 0)
                    l = LETTER_W'($urandom_range(0, 31));
                else
                    l = LETTER_W'(base + $urandom_range(0, span - 1));
                push_letter(l, (i == 0) && ($urandom_range(7) != 0), 1'b0, '0);
            end
        end
    endtask

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        pal_result_t got;
        pal_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.position       = m_tdata[0 +: POSITION_W];
            got.new_palindrome = m_tdata[NEWP_BIT];
            got.suffix_length  = m_tdata[SLEN_LO +: COUNT_W];
            got.suffix_count   = m_tdata[SCNT_LO +: COUNT_W];
            got.distinct_count = m_tdata[DCNT_LO +: COUNT_W];
            got.overflow       = m_tuser[0];
            if (suffix_reports.size() == 0)
            begin
                $display("%0t: result beat with none expected, expected nothing, got %h/%b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = suffix_reports.pop_front();
                compare_field("position", want.position, got.position);
                compare_field("new_palindrome", want.new_palindrome, got.new_palindrome);
                compare_field("suffix_length", want.suffix_length, got.suffix_length);
                compare_field("suffix_count", want.suffix_count, got.suffix_count);
                compare_field("distinct_count", want.distinct_count, got.distinct_count);
                compare_field("overflow", want.overflow, got.overflow);
            end
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    initial
    begin : stimulus
        int i;
        tree_clear();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            push_letter(directed_rows[i].letter, directed_rows[i].restart,
                        directed_rows[i].typed, directed_rows[i].res);
        short_texts(300);

        drain_results();
        tx_idle_pct = 63;
        rx_idle_pct = 33;
        // fill the text with one saturated letter, then run past the end
        push_letter(LETTER_W'($urandom_range(25, 31)), 1'b1, 1'b0, '0);
        for (i = 1; i < MAXL; i++)
            push_letter(LETTER_W'($urandom_range(25, 31)), 1'b0, 1'b0, '0);
        for (i = 0; i < 8; i++)
            push_letter(LETTER_W'($urandom_range(0, 31)), 1'b0, 1'b0, '0);

        drain_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_letter(LETTER_W'($urandom_range(0, 31)), 1'b1, 1'b0, '0);
        short_texts(300);

        drain_results();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/pstb_pkg.sv
rtl/pstb_core.sv
rtl/palindromic_suffix_tree_builder_unit.sv
tb/tb.sv
